### rtl/bsbl_pkg.sv
// Shared types and constants for the bounded sorted best list.
// No dependencies; imported by bsbl_cell and bounded_sorted_best_list_unit.
package bsbl_pkg;

    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int READ_N   = (CAPACITY < 16) ? CAPACITY : 16;

    localparam int SCORE_W  = 32;
    localparam int KEY_W    = 45;
    localparam int RANK_W   = 4;
    localparam int COUNT_W  = 5;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_READ   = 1'b1;

    typedef struct packed {
        logic                      kind;
        logic signed [SCORE_W-1:0] score;
        logic [KEY_W-1:0]          key_letters;
        logic [RANK_W-1:0]         read_index;
    } in_word_t;

    typedef struct packed {
        logic                      ok;
        logic [RANK_W-1:0]         rank;
        logic [COUNT_W-1:0]        entry_count;
        logic signed [SCORE_W-1:0] entry_score;
        logic [KEY_W-1:0]          entry_key;
    } out_word_t;

    // Contents of one list cell, handed right on a shift.
    typedef struct packed {
        logic                      occ;
        logic signed [SCORE_W-1:0] score;
        logic [KEY_W-1:0]          key;
    } cell_data_t;

endpackage

### rtl/bounded_sorted_best_list_unit.sv
// Top level of the bounded sorted best list: a row of bsbl_cell slots plus
// the entry counter, read select and output register. Depends on bsbl_pkg.
//
// Usage:
//   Input words arrive on s_valid/s_ready/s_data; results leave on
//   m_valid/m_ready/m_data, exactly one result word per input word.
//   An insert word (kind 0) is compared against every slot at once; the
//   slots at and right of its position shift right by one in the same cycle,
//   so the highest score falls off a full list. A read word (kind 1) selects
//   the slot at read_index.
//   m_valid rises in the cycle after acceptance. One word per cycle is
//   sustained while m_ready is high: the next word sees the list as left by
//   the previous one, as the whole slot row updates on the accepting edge.
//   The result sits in a single output register; s_ready is high while that
//   register is empty or is being drained, so a stalled receiver holds the
//   result and stops intake after one word.
//   aresetn (synchronous, active low) empties the list and drops any pending
//   result. Slot contents are not cleared; slots are marked empty instead.
module bounded_sorted_best_list_unit (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  bsbl_pkg::in_word_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output bsbl_pkg::out_word_t m_data
);
    import bsbl_pkg::*;

    logic             s_fire;
    logic             ins_en;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             m_valid_reg;
    out_word_t        m_data_reg;
    out_word_t        m_data_next;

    cell_data_t       cell_q    [CAPACITY];
    cell_data_t       cell_left [CAPACITY];
    logic [CAPACITY-1:0] ins_vec;
    logic [CAPACITY-1:0] left_ins_vec;
    logic [CAPACITY-1:0] occ_vec;
    logic [IDX_W-1:0]    pos;
    logic                ins_ok;
    cell_data_t          rd_data;

    assign s_ready = !m_valid_reg || m_ready;
    assign s_fire  = s_valid && s_ready;
    assign ins_en  = s_fire && (s_data.kind == KIND_INSERT);

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        if (i == 0) begin : g_head
            assign cell_left[i]    = '0;
            assign left_ins_vec[i] = 1'b0;
        end else begin : g_body
            assign cell_left[i]    = cell_q[i-1];
            assign left_ins_vec[i] = ins_vec[i-1];
        end

        bsbl_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ins_en    (ins_en),
            .new_score (s_data.score),
            .new_key   (s_data.key_letters),
            .left_data (cell_left[i]),
            .left_ins  (left_ins_vec[i]),
            .cell_data (cell_q[i]),
            .ins       (ins_vec[i])
        );

        assign occ_vec[i] = cell_q[i].occ;
    end

    // Last slot's flag is set unless every slot holds a score <= newcomer.
    assign ins_ok = ins_vec[CAPACITY-1];

    always_comb begin
        pos = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (ins_vec[i] && !left_ins_vec[i]) begin
                pos = pos | IDX_W'(i);
            end
        end
    end

    always_comb begin
        rd_data = '0;
        for (int i = 0; i < READ_N; i++) begin
            if (s_data.read_index == RANK_W'(i)) begin
                rd_data = cell_q[i];
            end
        end
    end

    always_comb begin
        count_next = count_reg;
        if (ins_en && ins_ok && (32'(count_reg) < CAPACITY)) begin
            count_next = count_reg + CNT_W'(1);
        end
    end

    always_comb begin
        m_data_next             = '0;
        m_data_next.entry_count = COUNT_W'(count_next);
        unique case (s_data.kind)
            KIND_INSERT: begin
                m_data_next.ok   = ins_ok;
                m_data_next.rank = ins_ok ? RANK_W'(pos) : '0;
            end
            KIND_READ: begin
                m_data_next.rank = s_data.read_index;
                if (32'(s_data.read_index) < 32'(count_reg)) begin
                    m_data_next.ok          = 1'b1;
                    m_data_next.entry_score = rd_data.score;
                    m_data_next.entry_key   = rd_data.key;
                end
            end
            default: begin
                m_data_next.ok = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            if (s_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Occupied slots always match the counter.
    a_count_matches_slots: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(occ_vec) == 32'(count_reg))
        else $error("slot occupancy differs from entry count");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(count_reg) <= CAPACITY)
        else $error("entry count above capacity");

    // A newcomer can only be discarded when the list is full.
    a_discard_only_full: assert property (@(posedge aclk) disable iff (!aresetn)
        ins_en && !ins_ok |-> 32'(count_reg) == CAPACITY)
        else $error("insert discarded on a list that is not full");

    // A read never changes the list size.
    a_read_keeps_count: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && (s_data.kind == KIND_READ) |=> count_reg == $past(count_reg))
        else $error("entry count changed on a read");

endmodule

### rtl/bsbl_cell.sv
// One slot of the sorted list: holds an entry, compares it with the newcomer,
// and either keeps it, takes the left neighbor's entry, or takes the newcomer.
// Depends on bsbl_pkg.
module bsbl_cell (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                ins_en,
    input  logic signed [bsbl_pkg::SCORE_W-1:0] new_score,
    input  logic [bsbl_pkg::KEY_W-1:0]          new_key,
    input  bsbl_pkg::cell_data_t                left_data,
    input  logic                                left_ins,
    output bsbl_pkg::cell_data_t                cell_data,
    output logic                                ins
);
    import bsbl_pkg::*;

    logic                      occ_reg;
    logic signed [SCORE_W-1:0] score_reg;
    logic [KEY_W-1:0]          key_reg;

    // Set from this slot rightward: empty, or holding a strictly greater score.
    assign ins = !occ_reg || (score_reg > new_score);

    assign cell_data.occ   = occ_reg;
    assign cell_data.score = score_reg;
    assign cell_data.key   = key_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg <= 1'b0;
        end else if (ins_en && ins) begin
            occ_reg <= left_ins ? left_data.occ : 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (ins_en && ins) begin
            if (left_ins) begin
                score_reg <= left_data.score;
                key_reg   <= left_data.key;
            end else begin
                score_reg <= new_score;
                key_reg   <= new_key;
            end
        end
    end

endmodule
